/* rtl/core/salc_pkg.sv */
package salc_pkg;

    // build-time geometry
    localparam int MAX_SET_BITS    = 8;
    localparam int MAX_WAYS        = 8;
    localparam int ADDR_BITS       = 64;
    localparam int STAMP_BITS      = 48;
    localparam int MAX_OFFSET_BITS = 16;

    localparam int NUM_SETS    = 1 << MAX_SET_BITS;
    localparam int NUM_LINES   = NUM_SETS * MAX_WAYS;
    localparam int SET_W       = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_CNT_W   = $clog2(MAX_WAYS + 1);
    localparam int TREE_LVLS   = $clog2(MAX_WAYS);
    localparam int TREE_N      = 1 << TREE_LVLS;
    localparam int DIRTY_CNT_W = $clog2(NUM_LINES + 1);

    // port field widths
    localparam int IN_ADDR_W  = 64;
    localparam int COUNT_W    = 32;
    localparam int DE_BYTES_W = 48;
    localparam int DB_BYTES_W = 28;

    localparam logic [IN_ADDR_W-1:0] ADDR_MASK = {IN_ADDR_W{1'b1}} >> (IN_ADDR_W - ADDR_BITS);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int SET_BITS_W = 4;
    localparam int OFF_BITS_W = 5;
    localparam int WAYS_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS        = 2'd2;

    localparam logic [SET_BITS_W-1:0] SET_BITS_RST = 4'd4;
    localparam logic [OFF_BITS_W-1:0] OFF_BITS_RST = 5'd4;
    localparam logic [WAYS_W-1:0]     WAYS_RST     = 4'd1;

    // access kinds
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    typedef struct packed {
        logic                  valid;
        logic                  dirty;
        logic [ADDR_BITS-1:0]  tag;
        logic [STAMP_BITS-1:0] last_use;
    } way_t;

    typedef way_t [MAX_WAYS-1:0] row_t;

    typedef struct packed {
        logic                 hit;
        logic [WAY_W-1:0]     hit_way;
        logic                 have_empty;
        logic [WAY_W-1:0]     empty_way;
        logic [WAY_W-1:0]     victim_way;
    } lookup_t;

    typedef struct packed {
        logic                 opcode;
        logic [IN_ADDR_W-1:0] address;
    } request_t;

    typedef struct packed {
        logic                  was_hit;
        logic                  was_eviction;
        logic                  evicted_dirty;
        logic [COUNT_W-1:0]    hit_count;
        logic [COUNT_W-1:0]    miss_count;
        logic [COUNT_W-1:0]    eviction_count;
        logic [DE_BYTES_W-1:0] dirty_eviction_bytes;
        logic [DB_BYTES_W-1:0] dirty_bytes_now;
    } response_t;

endpackage

/* rtl/core/salc_tag_ram.sv */
module salc_tag_ram
    import salc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [SET_W-1:0] rd_addr,
    output row_t             rd_row,
    input  logic             wr_en,
    input  logic [SET_W-1:0] wr_addr,
    input  row_t             wr_row
);

    row_t                mem [NUM_SETS];
    row_t                rd_data_reg;
    logic                rd_valid_reg;
    logic [NUM_SETS-1:0] row_valid_reg;

    // row storage, one row of all ways per set
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // per-row written flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    // a row never written reads as empty lines with zero use time
    always_comb
    begin
        rd_row = rd_data_reg;
        if (!rd_valid_reg)
        begin
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                rd_row[w].valid    = 1'b0;
                rd_row[w].dirty    = 1'b0;
                rd_row[w].last_use = '0;
            end
        end
    end

endmodule

/* rtl/core/salc_lookup.sv */
module salc_lookup
    import salc_pkg::*;
(
    input  row_t                 row,
    input  logic [ADDR_BITS-1:0] tag,
    input  logic [WAY_CNT_W-1:0] ways,
    output lookup_t              look
);

    logic [MAX_WAYS-1:0]   in_use;
    logic [STAMP_BITS-1:0] node_use [TREE_LVLS+1][TREE_N];
    logic [WAY_W-1:0]      node_idx [TREE_LVLS+1][TREE_N];
    logic                  node_ok  [TREE_LVLS+1][TREE_N];

    // ways taking part under the current geometry
    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            in_use[w] = (WAY_CNT_W'(w) < ways);
        end
    end

    // tag match (lowest way wins) and empty slot (highest way wins)
    always_comb
    begin
        look.hit        = 1'b0;
        look.hit_way    = '0;
        look.have_empty = 1'b0;
        look.empty_way  = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (in_use[w] && row[w].valid && (row[w].tag == tag))
            begin
                look.hit     = 1'b1;
                look.hit_way = WAY_W'(w);
            end
        end
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (in_use[w] && !row[w].valid)
            begin
                look.have_empty = 1'b1;
                look.empty_way  = WAY_W'(w);
            end
        end
        look.victim_way = node_idx[TREE_LVLS][0];
    end

    // oldest-use tree, ties go to the higher way
    always_comb
    begin
        node_use = '{default: '0};
        node_idx = '{default: '0};
        node_ok  = '{default: 1'b0};
        for (int n = 0; n < MAX_WAYS; n++)
        begin
            node_use[0][n] = row[n].last_use;
            node_idx[0][n] = WAY_W'(n);
            node_ok[0][n]  = in_use[n];
        end
        for (int l = 0; l < TREE_LVLS; l++)
        begin
            for (int n = 0; n < (TREE_N >> (l + 1)); n++)
            begin
                if (node_ok[l][2*n+1] &&
                    (!node_ok[l][2*n] || (node_use[l][2*n+1] <= node_use[l][2*n])))
                begin
                    node_use[l+1][n] = node_use[l][2*n+1];
                    node_idx[l+1][n] = node_idx[l][2*n+1];
                end
                else
                begin
                    node_use[l+1][n] = node_use[l][2*n];
                    node_idx[l+1][n] = node_idx[l][2*n];
                end
                node_ok[l+1][n] = node_ok[l][2*n] || node_ok[l][2*n+1];
            end
        end
    end

endmodule

/* rtl/core/set_assoc_lru_writeback_cache_tags.sv */
// Tag and state engine of a set-associative write-back cache with LRU
// replacement. An access is taken when start is high and busy is low; each
// access runs through the registered read of the set's row from
// the tag memory, then the lookup, victim choice and write back of the
// row; a new access waits for the last to finish. The result appears on
// response for exactly one cycle with done high and cannot be held off.
// Configuration writes through cfg_we/cfg_index/cfg_data take effect at once
// and are to be made only while the block is idle; they leave all lines and
// totals as they are. No clearing pass is needed after reset.
module set_assoc_lru_writeback_cache_tags
    import salc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  request_t              request,
    output logic                  done,
    output response_t             response
);

    // configuration registers
    logic [SET_BITS_W-1:0] set_bits_reg;
    logic [OFF_BITS_W-1:0] off_bits_reg;
    logic [WAYS_W-1:0]     ways_reg;

    logic [SET_BITS_W-1:0] sb_eff;
    logic [OFF_BITS_W-1:0] ob_eff;
    logic [WAY_CNT_W-1:0]  ways_eff;

    // access in flight
    logic                  busy_reg;
    logic                  op_reg;
    logic [SET_W-1:0]      set_reg;
    logic [ADDR_BITS-1:0]  tag_reg;

    // state and totals
    logic [STAMP_BITS-1:0]  stamp_reg;
    logic [COUNT_W-1:0]     hit_cnt_reg, hit_cnt_next;
    logic [COUNT_W-1:0]     miss_cnt_reg, miss_cnt_next;
    logic [COUNT_W-1:0]     evict_cnt_reg, evict_cnt_next;
    logic [COUNT_W-1:0]     dev_cnt_reg, dev_cnt_next;
    logic [DIRTY_CNT_W-1:0] dirty_cnt_reg, dirty_cnt_next;

    logic                   done_reg;
    response_t              resp_reg, resp_next;

    logic                   accept;
    logic [IN_ADDR_W-1:0]   addr_used;
    logic [IN_ADDR_W-1:0]   addr_shifted;
    logic [SET_W:0]         set_mask_wide;
    logic [SET_W-1:0]       set_idx;
    logic [5:0]             tag_shift;
    logic [ADDR_BITS-1:0]   tag_in;

    row_t                   rd_row;
    row_t                   wr_row;
    lookup_t                look;
    logic [WAY_W-1:0]       target;
    way_t                   old_way;
    way_t                   new_way;
    logic                   is_store;
    logic                   evict;
    logic                   dirty_inc;
    logic                   dirty_dec;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;
    assign done   = done_reg;
    assign response = resp_reg;

    // clamp configuration to the built geometry
    always_comb
    begin
        sb_eff = (int'(set_bits_reg) > MAX_SET_BITS) ? SET_BITS_W'(MAX_SET_BITS) : set_bits_reg;
        ob_eff = (int'(off_bits_reg) > MAX_OFFSET_BITS) ? OFF_BITS_W'(MAX_OFFSET_BITS)
                                                        : off_bits_reg;
        if (ways_reg == '0)
        begin
            ways_eff = WAY_CNT_W'(1);
        end
        else if (int'(ways_reg) > MAX_WAYS)
        begin
            ways_eff = WAY_CNT_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WAY_CNT_W'(ways_reg);
        end
    end

    // address split at the transfer of a request
    always_comb
    begin
        addr_used     = request.address & ADDR_MASK;
        addr_shifted  = addr_used >> ob_eff;
        set_mask_wide = ((SET_W+1)'(1) << sb_eff) - (SET_W+1)'(1);
        set_idx       = addr_shifted[SET_W-1:0] & set_mask_wide[SET_W-1:0];
        tag_shift     = 6'(sb_eff) + 6'(ob_eff);
        tag_in        = ADDR_BITS'(addr_used >> tag_shift);
    end

    salc_tag_ram u_ram
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (set_idx),
        .rd_row  (rd_row),
        .wr_en   (busy_reg),
        .wr_addr (set_reg),
        .wr_row  (wr_row)
    );

    salc_lookup u_lookup
    (
        .row  (rd_row),
        .tag  (tag_reg),
        .ways (ways_eff),
        .look (look)
    );

    // line update and row write back
    always_comb
    begin
        is_store = (op_reg == OP_STORE);
        evict    = !look.hit && !look.have_empty;
        if (look.hit)
        begin
            target = look.hit_way;
        end
        else if (look.have_empty)
        begin
            target = look.empty_way;
        end
        else
        begin
            target = look.victim_way;
        end
        old_way = rd_row[target];
        new_way = old_way;
        new_way.last_use = stamp_reg;
        if (look.hit)
        begin
            dirty_inc = is_store && !old_way.dirty;
            dirty_dec = 1'b0;
            if (is_store)
            begin
                new_way.dirty = 1'b1;
            end
        end
        else
        begin
            dirty_inc     = is_store;
            dirty_dec     = old_way.dirty;
            new_way.valid = 1'b1;
            new_way.tag   = tag_reg;
            new_way.dirty = is_store;
        end
        wr_row         = rd_row;
        wr_row[target] = new_way;
    end

    // saturating totals and the result word
    always_comb
    begin
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        evict_cnt_next = evict_cnt_reg;
        dev_cnt_next   = dev_cnt_reg;
        if (look.hit)
        begin
            if (hit_cnt_reg != '1)
            begin
                hit_cnt_next = hit_cnt_reg + COUNT_W'(1);
            end
        end
        else if (miss_cnt_reg != '1)
        begin
            miss_cnt_next = miss_cnt_reg + COUNT_W'(1);
        end
        if (evict && (evict_cnt_reg != '1))
        begin
            evict_cnt_next = evict_cnt_reg + COUNT_W'(1);
        end
        if (evict && old_way.dirty && (dev_cnt_reg != '1))
        begin
            dev_cnt_next = dev_cnt_reg + COUNT_W'(1);
        end
        dirty_cnt_next = dirty_cnt_reg + DIRTY_CNT_W'(dirty_inc) - DIRTY_CNT_W'(dirty_dec);

        resp_next.was_hit              = look.hit;
        resp_next.was_eviction         = evict;
        resp_next.evicted_dirty        = evict && old_way.dirty;
        resp_next.hit_count            = hit_cnt_next;
        resp_next.miss_count           = miss_cnt_next;
        resp_next.eviction_count       = evict_cnt_next;
        resp_next.dirty_eviction_bytes =
            DE_BYTES_W'({{(DE_BYTES_W-COUNT_W){1'b0}}, dev_cnt_next} << ob_eff);
        resp_next.dirty_bytes_now      =
            DB_BYTES_W'({{MAX_OFFSET_BITS{1'b0}}, dirty_cnt_next} << ob_eff);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg <= SET_BITS_RST;
            off_bits_reg <= OFF_BITS_RST;
            ways_reg     <= WAYS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SET_BITS:    set_bits_reg <= cfg_data[SET_BITS_W-1:0];
                REG_OFFSET_BITS: off_bits_reg <= cfg_data[OFF_BITS_W-1:0];
                REG_WAYS:        ways_reg     <= cfg_data[WAYS_W-1:0];
                default:         ;
            endcase
        end
    end

    // control and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            stamp_reg     <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
            dev_cnt_reg   <= '0;
            dirty_cnt_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                busy_reg      <= 1'b0;
                stamp_reg     <= stamp_reg + STAMP_BITS'(1);
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                evict_cnt_reg <= evict_cnt_next;
                dev_cnt_reg   <= dev_cnt_next;
                dirty_cnt_reg <= dirty_cnt_next;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= request.opcode;
            set_reg <= set_idx;
            tag_reg <= tag_in;
        end
        if (busy_reg)
        begin
            resp_reg <= resp_next;
        end
    end

    // a transfer is always followed by busy and then by one result
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done) ##1 (done && !busy))
        else $error("accepted access did not complete in two cycles");

    // result strobe only follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without an access in flight");

    // hit and eviction are exclusive
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(response.was_hit && response.was_eviction))
        else $error("eviction reported on a hit");

    // dirty line count stays within the number of lines
    a_dirty_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(dirty_cnt_reg) <= NUM_LINES)
        else $error("dirty line count out of range");

endmodule

/* bench/cache_tag_monitor.sv */
`timescale 1ns / 100ps

module cache_tag_monitor
    import salc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  start,
    input  logic                  busy,
    input  request_t              request,
    input  logic                  done,
    input  response_t             response,
    output int                    mismatches,
    output int                    compared,
    output int                    in_flight
);

    // shadow copy of the tag store
    logic                  shadow_valid [NUM_LINES];
    logic                  shadow_dirty [NUM_LINES];
    logic [ADDR_BITS-1:0]  shadow_tag   [NUM_LINES];
    logic [STAMP_BITS-1:0] shadow_use   [NUM_LINES];

    logic [STAMP_BITS-1:0] stamp;
    logic [COUNT_W-1:0]    hits;
    logic [COUNT_W-1:0]    misses;
    logic [COUNT_W-1:0]    evictions;
    logic [COUNT_W-1:0]    dirty_evict_total;
    logic [DIRTY_CNT_W-1:0] dirty_lines;

    // shadow geometry registers
    logic [SET_BITS_W-1:0] set_bits;
    logic [OFF_BITS_W-1:0] off_bits;
    logic [WAYS_W-1:0]     ways_reg;

    response_t pending_responses [$];

    always @(posedge clk or negedge rst_n) begin : track
        int sb;
        int ob;
        int nw;
        int set_idx;
        int base;
        int w;
        int slot;
        int empty_way;
        int victim;
        logic [63:0] addr;
        logic [63:0] tag;
        logic [STAMP_BITS-1:0] oldest;
        logic hit;
        logic have_empty;
        logic store;
        response_t want;

        if (!rst_n) begin
            for (int i = 0; i < NUM_LINES; i++) begin
                shadow_valid[i] = 1'b0;
                shadow_dirty[i] = 1'b0;
                shadow_tag[i]   = '0;
                shadow_use[i]   = '0;
            end
            stamp             <= '0;
            hits              <= '0;
            misses            <= '0;
            evictions         <= '0;
            dirty_evict_total <= '0;
            dirty_lines       = '0;
            set_bits          <= SET_BITS_RST;
            off_bits          <= OFF_BITS_RST;
            ways_reg          <= WAYS_RST;
            pending_responses.delete();
            mismatches        <= 0;
            compared          <= 0;
            in_flight         <= 0;
        end
        else begin
            // result transfer: compare with the oldest prediction
            if (done) begin
                if (pending_responses.size() == 0) begin
                    $error("response with no access outstanding");
                    mismatches <= mismatches + 1;
                end
                else begin
                    want = pending_responses.pop_front();
                    compared <= compared + 1;
                    if (response !== want)
                        mismatches <= mismatches + 1;
                    if (response.was_hit !== want.was_hit)
                        $error("was_hit: expected %0h, got %0h",
                               want.was_hit, response.was_hit);
                    if (response.was_eviction !== want.was_eviction)
                        $error("was_eviction: expected %0h, got %0h",
                               want.was_eviction, response.was_eviction);
                    if (response.evicted_dirty !== want.evicted_dirty)
                        $error("evicted_dirty: expected %0h, got %0h",
                               want.evicted_dirty, response.evicted_dirty);
                    if (response.hit_count !== want.hit_count)
                        $error("hit_count: expected %0h, got %0h",
                               want.hit_count, response.hit_count);
                    if (response.miss_count !== want.miss_count)
                        $error("miss_count: expected %0h, got %0h",
                               want.miss_count, response.miss_count);
                    if (response.eviction_count !== want.eviction_count)
                        $error("eviction_count: expected %0h, got %0h",
                               want.eviction_count, response.eviction_count);
                    if (response.dirty_eviction_bytes !== want.dirty_eviction_bytes)
                        $error("dirty_eviction_bytes: expected %0h, got %0h",
                               want.dirty_eviction_bytes, response.dirty_eviction_bytes);
                    if (response.dirty_bytes_now !== want.dirty_bytes_now)
                        $error("dirty_bytes_now: expected %0h, got %0h",
                               want.dirty_bytes_now, response.dirty_bytes_now);
                end
            end

            // register writes
            if (cfg_we) begin
                case (cfg_index)
                    REG_SET_BITS:    set_bits <= cfg_data[SET_BITS_W-1:0];
                    REG_OFFSET_BITS: off_bits <= cfg_data[OFF_BITS_W-1:0];
                    REG_WAYS:        ways_reg <= cfg_data[WAYS_W-1:0];
                    default: ;
                endcase
            end

            // access transfer: predict its response
            if (start && !busy) begin
                sb = (set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits);
                ob = (off_bits > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : int'(off_bits);
                nw = (ways_reg == 0) ? 1 : int'(ways_reg);
                if (nw > MAX_WAYS)
                    nw = MAX_WAYS;
                store = (request.opcode == OP_STORE);
                addr = request.address & ADDR_MASK;
                set_idx = int'((addr >> ob) & ((64'd1 << sb) - 64'd1));
                tag = addr >> (sb + ob);
                base = set_idx * MAX_WAYS;

                // lookup, highest empty way, oldest way with ties to the highest
                hit = 1'b0;
                have_empty = 1'b0;
                empty_way = 0;
                victim = 0;
                oldest = '0;
                slot = base;
                for (w = 0; w < nw && !hit; w++) begin
                    if (shadow_valid[base + w] && shadow_tag[base + w] == tag) begin
                        hit = 1'b1;
                        slot = base + w;
                    end
                    else begin
                        if (!shadow_valid[base + w]) begin
                            have_empty = 1'b1;
                            empty_way = w;
                        end
                        if (w == 0 || shadow_use[base + w] <= oldest) begin
                            oldest = shadow_use[base + w];
                            victim = w;
                        end
                    end
                end

                want = '0;
                want.was_hit = hit;
                want.hit_count = hits;
                want.miss_count = misses;
                want.eviction_count = evictions;
                want.dirty_eviction_bytes = DE_BYTES_W'(dirty_evict_total);
                if (hit) begin
                    if (hits != '1)
                        want.hit_count = hits + 1'b1;
                    shadow_use[slot] = stamp;
                    if (store && !shadow_dirty[slot]) begin
                        shadow_dirty[slot] = 1'b1;
                        dirty_lines = dirty_lines + 1'b1;
                    end
                end
                else begin
                    if (misses != '1)
                        want.miss_count = misses + 1'b1;
                    if (have_empty) begin
                        slot = base + empty_way;
                        // stale dirty mark on an empty line
                        if (shadow_dirty[slot]) begin
                            shadow_dirty[slot] = 1'b0;
                            dirty_lines = dirty_lines - 1'b1;
                        end
                    end
                    else begin
                        slot = base + victim;
                        want.was_eviction = 1'b1;
                        if (evictions != '1)
                            want.eviction_count = evictions + 1'b1;
                        if (shadow_dirty[slot]) begin
                            want.evicted_dirty = 1'b1;
                            if (dirty_evict_total != '1)
                                want.dirty_eviction_bytes =
                                    DE_BYTES_W'(dirty_evict_total + 1'b1);
                            shadow_dirty[slot] = 1'b0;
                            dirty_lines = dirty_lines - 1'b1;
                        end
                    end
                    shadow_valid[slot] = 1'b1;
                    shadow_tag[slot] = tag;
                    shadow_use[slot] = stamp;
                    if (store) begin
                        shadow_dirty[slot] = 1'b1;
                        dirty_lines = dirty_lines + 1'b1;
                    end
                end

                hits <= want.hit_count;
                misses <= want.miss_count;
                evictions <= want.eviction_count;
                dirty_evict_total <= want.dirty_eviction_bytes[COUNT_W-1:0];
                stamp <= stamp + 1'b1;

                // byte totals scale with the block size
                want.dirty_eviction_bytes =
                    DE_BYTES_W'(64'(want.dirty_eviction_bytes[COUNT_W-1:0]) << ob);
                want.dirty_bytes_now = DB_BYTES_W'(64'(dirty_lines) << ob);
                pending_responses.push_back(want);
            end

            in_flight <= pending_responses.size();
        end
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
    import salc_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 140;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  start = 1'b0;
    request_t              request = '0;
    logic                  busy;
    logic                  done;
    response_t             response;

    int mismatches;
    int compared;
    int in_flight;
    int stall_cycles = 0;
    int accesses = 0;
    int geometries = 0;

    // stimulus shaping for the current geometry
    logic [63:0] tag_pool [16];
    int eff_sb;
    int eff_ob;
    int eff_ways;
    int hot_set;
    int idle_pct;

    always #5 clk = ~clk;

    set_assoc_lru_writeback_cache_tags u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .response  (response)
    );

    cache_tag_monitor u_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .response   (response),
        .mismatches (mismatches),
        .compared   (compared),
        .in_flight  (in_flight)
    );

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT) begin
            $display("[set_assoc_lru_writeback_cache_tags] ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // one access, with random idle cycles ahead of it
    task automatic issue(input logic op, input logic [63:0] addr);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        request <= {op, addr};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        accesses++;
    endtask

    // hold off until every response is back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write all three geometry registers, block idle
    task automatic set_geometry(input int sb_raw, input int ob_raw, input int ways_raw);
        cfg_we <= 1'b1;
        cfg_index <= REG_SET_BITS;
        cfg_data <= CFG_DATA_W'(sb_raw);
        @(posedge clk);
        cfg_index <= REG_OFFSET_BITS;
        cfg_data <= CFG_DATA_W'(ob_raw);
        @(posedge clk);
        cfg_index <= REG_WAYS;
        cfg_data <= CFG_DATA_W'(ways_raw);
        @(posedge clk);
        cfg_we <= 1'b0;
        eff_sb = sb_raw % 16;
        if (eff_sb > MAX_SET_BITS)
            eff_sb = MAX_SET_BITS;
        eff_ob = ob_raw % 32;
        if (eff_ob > MAX_OFFSET_BITS)
            eff_ob = MAX_OFFSET_BITS;
        eff_ways = ways_raw % 16;
        if (eff_ways == 0)
            eff_ways = 1;
        if (eff_ways > MAX_WAYS)
            eff_ways = MAX_WAYS;
        foreach (tag_pool[i])
            tag_pool[i] = {$urandom, $urandom};
        hot_set = $urandom_range(0, NUM_SETS - 1);
        geometries++;
    endtask

    // mostly reuse of a few tags in a few sets, some noise
    task automatic random_access();
        logic [63:0] addr;
        logic [63:0] set_mask;
        logic [63:0] off_mask;
        int pick;
        pick = $urandom_range(0, (eff_ways + 1 < 15) ? eff_ways + 1 : 15);
        off_mask = (64'd1 << eff_ob) - 64'd1;
        set_mask = ((64'd1 << eff_sb) - 64'd1) << eff_ob;
        if ($urandom_range(0, 99) < 15)
            addr = {$urandom, $urandom};
        else
            addr = (tag_pool[pick] & ~(set_mask | off_mask))
                 | ((64'(hot_set + $urandom_range(0, 2)) << eff_ob) & set_mask)
                 | ({$urandom, $urandom} & off_mask);
        issue($urandom_range(0, 1) ? OP_STORE : OP_LOAD, addr);
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: 16 sets, 16-byte blocks, one way
        idle_pct = 0;
        issue(OP_LOAD,  64'h0);
        issue(OP_STORE, 64'h8);
        issue(OP_LOAD,  64'h100);
        issue(OP_LOAD,  64'h200);
        issue(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
        issue(OP_LOAD,  64'hFFFF_FFFF_FFFF_FFF0);
        issue(OP_STORE, 64'h0000_0000_0000_00F0);
        drain();

        // two sets of two ways on byte blocks, lines kept across the change
        set_geometry(1, 0, 2);
        issue(OP_STORE, 64'h0);
        issue(OP_STORE, 64'h2);
        issue(OP_LOAD,  64'h4);
        issue(OP_LOAD,  64'h2);
        issue(OP_STORE, 64'h6);
        issue(OP_LOAD,  64'h8000_0000_0000_0000);
        issue(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
        issue(OP_LOAD,  64'h5555_5555_5555_5555);
        issue(OP_STORE, 64'hAAAA_AAAA_AAAA_AAAA);
        issue(OP_LOAD,  64'h3);
        issue(OP_STORE, 64'h1);
        issue(OP_LOAD,  64'h8000_0000_0000_0000);
        drain();

        // random phases over a spread of geometries and idle rates
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_geometry(0, 0, 8);
                1: set_geometry(8, 16, 8);
                2: set_geometry(15, 31, 15);
                3: set_geometry(2, 5, 0);
                4: set_geometry(3, 3, 4);
                6: set_geometry(4, 6, 2);
                default: set_geometry($urandom_range(0, 31), $urandom_range(0, 31),
                                      $urandom_range(0, 31));
            endcase
            case (phase % 3)
                0: idle_pct = 0;
                1: idle_pct = 84;
                default: idle_pct = 37;
            endcase
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 59) == 0)
                    drain();
                random_access();
            end
            drain();
        end

        $display("covered %0d accesses over %0d geometries, %0d responses compared",
                 accesses, geometries, compared);
        $display("including load/store hits, fills, clean and dirty evictions");
        if (mismatches == 0 && in_flight == 0)
            $display("[set_assoc_lru_writeback_cache_tags] OK");
        else
            $display("[set_assoc_lru_writeback_cache_tags] ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/core/salc_pkg.sv
rtl/core/salc_tag_ram.sv
rtl/core/salc_lookup.sv
rtl/core/set_assoc_lru_writeback_cache_tags.sv
bench/cache_tag_monitor.sv
bench/tb.sv
